// ===== design/srfu_pkg.sv =====
// Package for the sensor record field unpacker.
// Holds the beat types, record kind codes, field sentinels and queue sizing.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srfu_pkg;

   localparam int PAYLOAD_BYTES = 21;
   localparam int PAYLOAD_W     = 168;
   localparam int PAYLOAD_BITS  = PAYLOAD_BYTES * 8;
   localparam logic [PAYLOAD_W-1:0] PAYLOAD_MASK = {PAYLOAD_W{1'b1}} >> (PAYLOAD_W - PAYLOAD_BITS);

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] KIND_SOLAR    = 3'd0;
   localparam logic [2:0] KIND_BATTERY  = 3'd1;
   localparam logic [2:0] KIND_INVERTER = 3'd2;
   localparam logic [2:0] KIND_DCDC     = 3'd3;
   localparam logic [2:0] KIND_CHARGER  = 3'd4;

   localparam logic [8:0]  SENTINEL_9BIT  = 9'h1FF;
   localparam logic [12:0] SENTINEL_13BIT = 13'h1FFF;
   localparam logic [10:0] SENTINEL_11BIT = 11'h7FF;
   localparam logic [6:0]  SENTINEL_7BIT  = 7'h7F;
   localparam logic [1:0]  AUX_MODE_VOLTAGE = 2'd0;
   localparam logic [1:0]  AUX_MODE_TEMP    = 2'd2;
   localparam logic [23:0] KELVIN_OFFSET    = 24'd27315;
   localparam logic [23:0] CHARGER_TEMP_OFFSET = 24'd40;

   typedef struct packed {
      logic [2:0]  kind;
      logic [63:0] payload_low;
      logic [63:0] payload_mid;
      logic [39:0] payload_high;
   } req_type;

   typedef struct packed {
      logic [3:0]         quantity;
      logic signed [23:0] reading;
      logic               valid_res;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]           kind;
      logic [3:0]           count;
      logic [PAYLOAD_W-1:0] payload;
   } item_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   function automatic logic [3:0] srfu_count(input logic [2:0] kind);
      logic [3:0] n;
      n = 4'd0;
      case (kind)
         KIND_SOLAR:    if (PAYLOAD_BYTES >= 12) n = 4'd7;
         KIND_BATTERY:  if (PAYLOAD_BYTES >= 15) n = 4'd9;
         KIND_INVERTER: if (PAYLOAD_BYTES >= 9)  n = 4'd5;
         KIND_DCDC:     if (PAYLOAD_BYTES >= 8)  n = 4'd5;
         KIND_CHARGER:  if (PAYLOAD_BYTES >= 13) n = 4'd10;
         default:       n = 4'd0;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== design/srfu_front.sv =====
// Front end of the unpacker: accepts request beats, masks the payload and
// classifies the record kind into a result count. Uses srfu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srfu_front import srfu_pkg::*; (
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_payload,
   input  wire queue_status_type q_status,
   output logic                  push,
   output item_type              push_item
);

   logic [3:0] count;

   assign count     = srfu_count(req_payload.kind);
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full && (count != 4'd0);

   always_comb begin
      push_item.kind    = req_payload.kind;
      push_item.count   = count;
      push_item.payload = {req_payload.payload_high, req_payload.payload_mid,
                           req_payload.payload_low} & PAYLOAD_MASK;
   end

endmodule

`default_nettype wire

// ===== design/srfu_queue.sv =====
// Short record queue between the front end and the back end.
// Register array with read and write pointers. Uses srfu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srfu_queue import srfu_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire item_type  push_item,
   input  wire logic      pop,
   output item_type       head,
   output queue_status_type q_status
);

   item_type                 mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   cnt_ff, cnt_in;

   function automatic logic [QUEUE_PTR_W-1:0] next_ptr(input logic [QUEUE_PTR_W-1:0] p);
      if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) return '0;
      return p + 1'b1;
   endfunction

   assign head               = mem_ff[rd_ptr_ff];
   assign q_status.full      = (cnt_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_status.not_empty = (cnt_ff != '0);

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== design/srfu_back.sv =====
// Back end of the unpacker: steps through the head record's quantities,
// one per cycle unless stalled, into the response register. Uses srfu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srfu_back import srfu_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire item_type head,
   input  wire logic     head_valid,
   output logic          pop,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output rsp_type       rsp_payload
);

   logic [3:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       load;
   logic       is_last;
   logic [24:0] field;

   function automatic logic [24:0] extract(input logic [2:0] kind, input logic [3:0] idx,
                                           input logic [PAYLOAD_W-1:0] p);
      logic [23:0] r;
      logic        v;
      logic [15:0] aux;
      logic [1:0]  mode;
      r    = '0;
      v    = 1'b1;
      aux  = p[63:48];
      mode = p[65:64];
      case (kind)
         KIND_SOLAR: begin
            case (idx)
               4'd0: r = {16'd0, p[7:0]};
               4'd1: r = {16'd0, p[15:8]};
               4'd2: r = {{8{p[31]}}, p[31:16]};
               4'd3: r = {{8{p[47]}}, p[47:32]};
               4'd4: r = {8'd0, p[63:48]};
               4'd5: r = {8'd0, p[79:64]};
               4'd6: begin
                  r = {15'd0, p[88:80]};
                  v = (p[88:80] != SENTINEL_9BIT);
               end
               default: v = 1'b0;
            endcase
         end
         KIND_BATTERY: begin
            case (idx)
               4'd0: r = {8'd0, p[15:0]};
               4'd1: r = {{8{p[31]}}, p[31:16]};
               4'd2: r = {8'd0, p[47:32]};
               4'd3: r = {22'd0, mode};
               4'd4: begin
                  r = {8'd0, aux};
                  v = (mode == AUX_MODE_VOLTAGE);
               end
               4'd5: begin
                  r = {8'd0, aux} - KELVIN_OFFSET;
                  v = (mode == AUX_MODE_TEMP);
               end
               4'd6: r = {{2{p[87]}}, p[87:66]};
               4'd7: r = 24'd0 - {4'd0, p[107:88]};
               4'd8: r = {14'd0, p[117:108]};
               default: v = 1'b0;
            endcase
         end
         KIND_INVERTER: begin
            case (idx)
               4'd0: r = {16'd0, p[7:0]};
               4'd1: r = {8'd0, p[31:16]};
               4'd2: r = {{8{p[47]}}, p[47:32]};
               4'd3: r = p[71:48];
               4'd4: r = {16'd0, p[79:72]};
               default: v = 1'b0;
            endcase
         end
         KIND_DCDC: begin
            case (idx)
               4'd0: r = {16'd0, p[7:0]};
               4'd1: r = {16'd0, p[15:8]};
               4'd2: r = {8'd0, p[31:16]};
               4'd3: r = {8'd0, p[47:32]};
               4'd4: r = {8'd0, p[63:48]};
               default: v = 1'b0;
            endcase
         end
         KIND_CHARGER: begin
            case (idx)
               4'd0: r = {16'd0, p[7:0]};
               4'd1: r = {16'd0, p[15:8]};
               4'd2: begin
                  r = {11'd0, p[28:16]};
                  v = (p[28:16] != SENTINEL_13BIT);
               end
               4'd3: begin
                  r = {13'd0, p[39:29]};
                  v = (p[39:29] != SENTINEL_11BIT);
               end
               4'd4: begin
                  r = {11'd0, p[52:40]};
                  v = (p[52:40] != SENTINEL_13BIT);
               end
               4'd5: begin
                  r = {13'd0, p[63:53]};
                  v = (p[63:53] != SENTINEL_11BIT);
               end
               4'd6: begin
                  r = {11'd0, p[76:64]};
                  v = (p[76:64] != SENTINEL_13BIT);
               end
               4'd7: begin
                  r = {13'd0, p[87:77]};
                  v = (p[87:77] != SENTINEL_11BIT);
               end
               4'd8: begin
                  r = {17'd0, p[94:88]} - CHARGER_TEMP_OFFSET;
                  v = (p[94:88] != SENTINEL_7BIT);
               end
               4'd9: begin
                  r = {15'd0, p[103:95]};
                  v = (p[103:95] != SENTINEL_9BIT);
               end
               default: v = 1'b0;
            endcase
         end
         default: v = 1'b0;
      endcase
      if (!v) r = '0;
      return {v, r};
   endfunction

   assign field   = extract(head.kind, idx_ff, head.payload);
   assign load    = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign is_last = (idx_ff == head.count - 4'd1);
   assign pop     = load && is_last;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.quantity    = idx_ff;
         rsp_in.reading     = field[23:0];
         rsp_in.valid_res   = field[24];
         rsp_in.last        = is_last;
         idx_in             = is_last ? 4'd0 : idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

// ===== design/sensor_record_field_unpacker.sv =====
// Top level of the sensor record field unpacker.
// Instantiates srfu_front, srfu_queue and srfu_back; uses srfu_pkg.
//
// A request beat carries a record kind and a 21-byte decrypted payload. The
// block answers with one response beat per quantity of that kind: 7 for a
// solar charger, 9 for a battery monitor, 5 for an inverter or DC-DC
// converter, 10 for an AC charger. The final beat of a record has last set.
// A request with an unknown kind is accepted and gives no response beats.
// The first response beat of a record passes through its queue entry and
// then the response register, and the rest follow one per cycle while
// rsp_stall stays low. The single response register, fed one quantity per
// cycle from the record at the queue head, sets that rate. A two-entry
// queue holds accepted records, so new requests are taken while a record
// is still being unpacked; req_stall is high only while that queue is full.
// A stalled response beat holds its value. Synchronous reset empties the
// queue and drops any pending response.
`timescale 1ns / 1ps
`default_nettype none

module sensor_record_field_unpacker import srfu_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   queue_status_type q_status;
   item_type         push_item;
   item_type         head;
   logic             push;
   logic             pop;

   srfu_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_status    (q_status),
      .push        (push),
      .push_item   (push_item)
   );

   srfu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .q_status  (q_status)
   );

   srfu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .head_valid  (q_status.not_empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== design/srfu_checker.sv =====
// Port-level checker for the sensor record field unpacker, with its bind.
// Uses srfu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srfu_checker import srfu_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_payload
);

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("Stalled response beat changed.");

   a_next_quantity : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_payload.last |=>
         rsp_valid && (rsp_payload.quantity == $past(rsp_payload.quantity) + 4'd1))
      else $error("Quantity sequence broken within a record.");

   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.valid_res |-> rsp_payload.reading == 24'sd0)
      else $error("Invalid reading is not zero.");

   a_quantity_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.quantity <= 4'd9)
      else $error("Quantity index out of range.");

   a_reset_idle : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response valid right after reset.");

endmodule

bind sensor_record_field_unpacker srfu_checker u_srfu_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

// ===== dv/tb_sensor_record_field_unpacker.sv =====
// Self-checking testbench for the sensor record field unpacker.
// Drives directed and random record beats, predicts every quantity beat and
// checks it field by field. Depends on srfu_pkg and sensor_record_field_unpacker.
`timescale 1ns / 1ps

module tb_sensor_record_field_unpacker;
   import srfu_pkg::*;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int HOLD_CYCLES    = 60;
   localparam int RANDOM_PER_PHASE = 145;
   localparam int KELVIN_BIAS    = 27315;
   localparam int CHARGER_BIAS   = 40;
   localparam logic [2:0] KIND_SPARE_A = 3'd5;
   localparam logic [2:0] KIND_SPARE_B = 3'd6;
   localparam logic [2:0] KIND_SPARE_C = 3'd7;

   typedef struct {
      req_type            req;
      bit                 spot;
      logic [3:0]         spot_q;
      logic signed [23:0] spot_reading;
      logic               spot_valid;
   } probe_row;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   rsp_type  pending_quantities[$];
   probe_row probes[$];
   int       mismatches = 0;
   int       beats_checked = 0;
   int       cycle_count = 0;
   int       records_by_kind[8];
   int       tx_idle_pct = 0;
   int       rx_idle_pct = 0;
   int       hold_tickets = 0;

   sensor_record_field_unpacker dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH at %0t ns: %s", $time, msg);
   endtask

   function automatic int unpack_record(input req_type r);
      logic [PAYLOAD_W-1:0] p;
      logic signed [23:0]   val[10];
      bit                   ok[10];
      int                   cnt;
      int                   base;
      rsp_type              beat;
      p = {r.payload_high, r.payload_mid, r.payload_low} & PAYLOAD_MASK;
      cnt = 0;
      for (int i = 0; i < 10; i++) begin
         val[i] = '0;
         ok[i]  = 1'b1;
      end
      case (r.kind)
         KIND_SOLAR: if (PAYLOAD_BYTES >= 12) begin
            cnt    = 7;
            val[0] = p[7:0];
            val[1] = p[15:8];
            val[2] = {{8{p[31]}}, p[31:16]};
            val[3] = {{8{p[47]}}, p[47:32]};
            val[4] = p[63:48];
            val[5] = p[79:64];
            val[6] = p[88:80];
            ok[6]  = (p[88:80] != 9'h1FF);
         end
         KIND_BATTERY: if (PAYLOAD_BYTES >= 15) begin
            cnt    = 9;
            val[0] = p[15:0];
            val[1] = {{8{p[31]}}, p[31:16]};
            val[2] = p[47:32];
            val[3] = p[65:64];
            val[4] = p[63:48];
            ok[4]  = (p[65:64] == AUX_MODE_VOLTAGE);
            val[5] = 24'(p[63:48] - KELVIN_BIAS);
            ok[5]  = (p[65:64] == AUX_MODE_TEMP);
            val[6] = {{2{p[87]}}, p[87:66]};
            val[7] = 24'd0 - p[107:88];
            val[8] = p[117:108];
         end
         KIND_INVERTER: if (PAYLOAD_BYTES >= 9) begin
            cnt    = 5;
            val[0] = p[7:0];
            val[1] = p[31:16];
            val[2] = {{8{p[47]}}, p[47:32]};
            val[3] = p[71:48];
            val[4] = (PAYLOAD_BYTES > 9) ? p[79:72] : 8'd0;
         end
         KIND_DCDC: if (PAYLOAD_BYTES >= 8) begin
            cnt    = 5;
            val[0] = p[7:0];
            val[1] = p[15:8];
            val[2] = p[31:16];
            val[3] = p[47:32];
            val[4] = p[63:48];
         end
         KIND_CHARGER: if (PAYLOAD_BYTES >= 13) begin
            cnt    = 10;
            val[0] = p[7:0];
            val[1] = p[15:8];
            for (int k = 0; k < 3; k++) begin
               base         = 16 + 24 * k;
               val[2 + 2*k] = p[base +: 13];
               ok[2 + 2*k]  = (p[base +: 13] != 13'h1FFF);
               val[3 + 2*k] = p[base + 13 +: 11];
               ok[3 + 2*k]  = (p[base + 13 +: 11] != 11'h7FF);
            end
            val[8] = 24'(p[94:88] - CHARGER_BIAS);
            ok[8]  = (p[94:88] != 7'h7F);
            val[9] = p[103:95];
            ok[9]  = (p[103:95] != 9'h1FF);
         end
         default: cnt = 0;
      endcase
      for (int i = 0; i < cnt; i++) begin
         beat.quantity  = 4'(i);
         beat.reading   = ok[i] ? val[i] : 24'sd0;
         beat.valid_res = ok[i];
         beat.last      = (i == cnt - 1);
         pending_quantities.push_back(beat);
      end
      return cnt;
   endfunction

   function automatic probe_row probe(input logic [2:0] kind, input logic [63:0] low,
                                      input logic [63:0] mid, input logic [39:0] high,
                                      input bit spot, input logic [3:0] q,
                                      input logic signed [23:0] reading, input logic ok);
      probe_row row;
      row.req.kind         = kind;
      row.req.payload_low  = low;
      row.req.payload_mid  = mid;
      row.req.payload_high = high;
      row.spot             = spot;
      row.spot_q           = q;
      row.spot_reading     = reading;
      row.spot_valid       = ok;
      return row;
   endfunction

   function automatic req_type random_record();
      logic [191:0] raw;
      logic [PAYLOAD_W-1:0] p;
      req_type r;
      int style;
      raw   = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      p     = raw[PAYLOAD_W-1:0];
      style = $urandom_range(9);
      if (style == 0) begin
         p = '1;
      end else if (style == 1) begin
         p = '0;
      end
      if ($urandom_range(99) < 5) begin
         r.kind = 3'(KIND_SPARE_A + $urandom_range(2));
      end else begin
         r.kind = 3'($urandom_range(4));
      end
      if (r.kind == KIND_SOLAR && $urandom_range(3) == 0) begin
         p[88:80] = '1;
      end
      if (r.kind == KIND_CHARGER) begin
         for (int k = 0; k < 3; k++) begin
            if ($urandom_range(4) == 0) p[16 + 24*k +: 13] = '1;
            if ($urandom_range(4) == 0) p[29 + 24*k +: 11] = '1;
         end
         if ($urandom_range(4) == 0) p[94:88] = '1;
         if ($urandom_range(4) == 0) p[103:95] = '1;
      end
      r.payload_low  = p[63:0];
      r.payload_mid  = p[127:64];
      r.payload_high = p[167:128];
      return r;
   endfunction

   task automatic send_record(input req_type r, output int produced);
      if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 3)) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      records_by_kind[r.kind]++;
      produced = unpack_record(r);
   endtask

   task automatic go_quiet_and_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_quantities.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic check_quantity_beat(input rsp_type got);
      rsp_type want;
      beats_checked++;
      if (pending_quantities.size() == 0) begin
         report_mismatch($sformatf("beat with nothing pending: quantity %0d reading %0d",
                                   got.quantity, got.reading));
      end else begin
         want = pending_quantities.pop_front();
         if (got.quantity !== want.quantity)
            report_mismatch($sformatf("quantity %0d, wanted %0d", got.quantity, want.quantity));
         if (got.reading !== want.reading)
            report_mismatch($sformatf("quantity %0d reading %0d, wanted %0d",
                                      want.quantity, got.reading, want.reading));
         if (got.valid_res !== want.valid_res)
            report_mismatch($sformatf("quantity %0d valid_res %b, wanted %b",
                                      want.quantity, got.valid_res, want.valid_res));
         if (got.last !== want.last)
            report_mismatch($sformatf("quantity %0d last %b, wanted %b",
                                      want.quantity, got.last, want.last));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         check_quantity_beat(rsp_payload);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sensor_record_field_unpacker regression: fail");
         $finish;
      end
   end

   initial begin : receiver
      int hold_left;
      int served;
      hold_left = 0;
      served    = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (served != hold_tickets) begin
            served    = hold_tickets;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct);
         end
      end
   end

   initial begin : stimulus
      int      produced;
      int      idx;
      int      counted;
      req_type r;
      rsp_type e;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      foreach (records_by_kind[i]) records_by_kind[i] = 0;

      probes.push_back(probe(KIND_SOLAR, '0, '0, '0, 1, 0, 0, 1));
      probes.push_back(probe(KIND_SOLAR, '1, '1, '1, 1, 6, 0, 0));
      probes.push_back(probe(KIND_SOLAR, 64'h0000_0000_8000_0000, '0, '0, 1, 2, -32768, 1));
      probes.push_back(probe(KIND_SOLAR, 64'h1234_5678_9ABC_DEF0, 64'h0000_0000_01FE_ABCD,
                             '0, 1, 6, 510, 1));
      probes.push_back(probe(KIND_SOLAR, '0, '0, '1, 1, 0, 0, 1));
      probes.push_back(probe(KIND_BATTERY, 64'hFFFF_0000_0000_0000, '0, '0, 1, 4, 65535, 1));
      probes.push_back(probe(KIND_BATTERY, '0, 64'h2, '0, 1, 5, -27315, 1));
      probes.push_back(probe(KIND_BATTERY, '0, 64'h1, '0, 1, 5, 0, 0));
      probes.push_back(probe(KIND_BATTERY, '1, '1, '1, 1, 7, -1048575, 1));
      probes.push_back(probe(KIND_BATTERY, 64'hFFFF_0000_0000_0000, 64'h2, '0, 1, 5, 38220, 1));
      probes.push_back(probe(KIND_BATTERY, '0, 64'h0080_0000, '0, 1, 6, -2097152, 1));
      probes.push_back(probe(KIND_INVERTER, '1, '1, '1, 1, 3, -1, 1));
      probes.push_back(probe(KIND_INVERTER, '0, 64'h80, '0, 1, 3, -8388608, 1));
      probes.push_back(probe(KIND_INVERTER, 64'hFFFF_0000_0000_0000, 64'h7F, '0,
                             1, 3, 8388607, 1));
      probes.push_back(probe(KIND_INVERTER, '0, '0, '0, 1, 4, 0, 1));
      probes.push_back(probe(KIND_DCDC, '1, '1, '1, 1, 4, 65535, 1));
      probes.push_back(probe(KIND_DCDC, '0, '0, '0, 1, 0, 0, 1));
      probes.push_back(probe(KIND_CHARGER, '1, '1, '1, 1, 8, 0, 0));
      probes.push_back(probe(KIND_CHARGER, '0, '0, '0, 1, 8, -40, 1));
      probes.push_back(probe(KIND_CHARGER, '0, 64'h7E00_0000, '0, 1, 8, 86, 1));
      probes.push_back(probe(KIND_CHARGER, 64'h1FFE_0000, '0, '0, 1, 2, 8190, 1));
      probes.push_back(probe(KIND_CHARGER, '1, '0, '0, 1, 3, 0, 0));
      probes.push_back(probe(KIND_SPARE_A, '1, '1, '1, 0, 0, 0, 0));
      probes.push_back(probe(KIND_SPARE_B, '1, '1, '1, 0, 0, 0, 0));
      probes.push_back(probe(KIND_SPARE_C, '0, '0, '0, 0, 0, 0, 0));

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      tx_idle_pct = 8;
      rx_idle_pct = 53;
      foreach (probes[i]) begin
         send_record(probes[i].req, produced);
         if (probes[i].spot && probes[i].spot_q < produced) begin
            idx = pending_quantities.size() - produced + probes[i].spot_q;
            e   = pending_quantities[idx];
            if (e.reading !== probes[i].spot_reading || e.valid_res !== probes[i].spot_valid)
               report_mismatch($sformatf("directed row %0d: predictor gives %0d/%b", i,
                                         e.reading, e.valid_res));
            e.reading   = probes[i].spot_reading;
            e.valid_res = probes[i].spot_valid;
            pending_quantities[idx] = e;
         end
      end
      go_quiet_and_drain();

      for (int phase = 0; phase < 3; phase++) begin
         tx_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 53 : 0;
         rx_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 8 : 0;
         if (phase == 2) hold_tickets++;
         counted = 0;
         while (counted < RANDOM_PER_PHASE) begin
            r = random_record();
            send_record(r, produced);
            if (produced > 0) counted++;
            if (phase == 0 && counted == 40 && produced > 0) hold_tickets++;
         end
         go_quiet_and_drain();
      end

      $display("Covered %0d records: solar %0d, battery %0d, inverter %0d, dc-dc %0d,",
               records_by_kind.sum(), records_by_kind[KIND_SOLAR],
               records_by_kind[KIND_BATTERY], records_by_kind[KIND_INVERTER],
               records_by_kind[KIND_DCDC]);
      $display("ac charger %0d, unknown kind %0d; %0d quantity beats checked, %0d mismatches.",
               records_by_kind[KIND_CHARGER],
               records_by_kind[KIND_SPARE_A] + records_by_kind[KIND_SPARE_B]
               + records_by_kind[KIND_SPARE_C], beats_checked, mismatches);
      if (mismatches == 0) begin
         $display("sensor_record_field_unpacker regression: pass");
      end else begin
         $display("sensor_record_field_unpacker regression: fail");
      end
      $finish;
   end

endmodule
